// ===== rtl/core/stv_pkg.sv =====
// shared types, constants and helpers of the string type validator
package stv_pkg;

  // fixed widths of the item fields
  localparam int MODE_W = 4;
  localparam int CHAR_W = 8;

  // sizes
  localparam int DEPTH_BITS  = 16;
  localparam int KEY_HEX_LEN = 64;
  localparam int CNT_W       = 7;

  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] KEY_LEN_C = CNT_W'(KEY_HEX_LEN);
  localparam logic             KEY_EVEN  = ((KEY_HEX_LEN % 2) == 0);

  // string types
  localparam logic [MODE_W-1:0] MODE_ID    = 4'd0;
  localparam logic [MODE_W-1:0] MODE_PUB   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_RELAY = 4'd2;
  localparam logic [MODE_W-1:0] MODE_KIND  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_TIME  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_HEX   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_JSON  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_ADDR  = 4'd7;
  localparam logic [MODE_W-1:0] MODE_FREE  = 4'd8;

  // address phases
  localparam logic [1:0] PH_KIND = 2'd0;
  localparam logic [1:0] PH_KEY  = 2'd1;
  localparam logic [1:0] PH_TAG  = 2'd2;

  // relay prefix lengths
  localparam logic [CNT_W-1:0] WSS_LEN = CNT_W'(6);
  localparam logic [CNT_W-1:0] WS_LEN  = CNT_W'(5);

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic              char_present;
    logic              last;
  } item_t;

  typedef struct packed {
    logic is_hex;
    logic is_dec;
    logic is_white;
    logic is_colon;
    logic is_open;
    logic is_close;
    logic is_quote;
    logic is_bslash;
  } char_class_t;

  // "wss://" by position
  function automatic logic [CHAR_W-1:0] wss_char(input logic [2:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      3'd0:    c = 8'h77;
      3'd1:    c = 8'h73;
      3'd2:    c = 8'h73;
      3'd3:    c = 8'h3A;
      3'd4:    c = 8'h2F;
      3'd5:    c = 8'h2F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "ws://" by position
  function automatic logic [CHAR_W-1:0] ws_char(input logic [2:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      3'd0:    c = 8'h77;
      3'd1:    c = 8'h73;
      3'd2:    c = 8'h3A;
      3'd3:    c = 8'h2F;
      3'd4:    c = 8'h2F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/stv_char_class.sv =====
// byte classifier: hex, decimal, white space and json punctuation
module stv_char_class (
  input  logic [stv_pkg::CHAR_W-1:0] char_code,
  output stv_pkg::char_class_t       cls
);
  import stv_pkg::*;

  always_comb begin
    cls.is_dec    = (char_code >= 8'h30) && (char_code <= 8'h39);
    cls.is_hex    = cls.is_dec
                  || ((char_code >= 8'h61) && (char_code <= 8'h66))
                  || ((char_code >= 8'h41) && (char_code <= 8'h46));
    cls.is_white  = (char_code == 8'h20) || ((char_code >= 8'h09) && (char_code <= 8'h0D));
    cls.is_colon  = (char_code == 8'h3A);
    cls.is_open   = (char_code == 8'h7B) || (char_code == 8'h5B);
    cls.is_close  = (char_code == 8'h7D) || (char_code == 8'h5D);
    cls.is_quote  = (char_code == 8'h22);
    cls.is_bslash = (char_code == 8'h5C);
  end

endmodule

// ===== rtl/core/stv_check_core.sv =====
// per-string check state, its update for one item and the verdict
module stv_check_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  stv_pkg::item_t       item,
  input  stv_pkg::char_class_t cls,
  output logic                 verdict
);
  import stv_pkg::*;

  logic [MODE_W-1:0]     latched_type_r, latched_type_nxt;
  logic                  in_progress_r, in_progress_nxt;
  logic                  still_ok_r, still_ok_nxt;
  logic [CNT_W-1:0]      char_count_r, char_count_nxt;
  logic [CNT_W-1:0]      field_count_r, field_count_nxt;
  logic [1:0]            addr_phase_r, addr_phase_nxt;
  logic                  wss_match_r, wss_match_nxt;
  logic                  ws_match_r, ws_match_nxt;
  logic                  seen_nonspace_r, seen_nonspace_nxt;
  logic                  inside_quotes_r, inside_quotes_nxt;
  logic                  escape_pending_r, escape_pending_nxt;
  logic [DEPTH_BITS-1:0] nest_depth_r, nest_depth_nxt;

  logic [MODE_W-1:0]     typ;
  logic                  ok;
  logic [CNT_W-1:0]      cc;
  logic [CNT_W-1:0]      fc;
  logic [1:0]            ph;
  logic                  wss_m, ws_m, seen, inq, esc;
  logic [DEPTH_BITS-1:0] dep;

  always_comb begin
    typ  = in_progress_r ? latched_type_r : item.mode;
    ok   = still_ok_r;
    cc   = char_count_r;
    fc   = field_count_r;
    ph   = addr_phase_r;
    wss_m = wss_match_r;
    ws_m = ws_match_r;
    seen = seen_nonspace_r;
    inq  = inside_quotes_r;
    esc  = escape_pending_r;
    dep  = nest_depth_r;

    if (item.char_present) begin
      unique case (typ)
        MODE_ID, MODE_PUB, MODE_HEX: begin
          if (!cls.is_hex) ok = 1'b0;
          if (typ == MODE_HEX) fc = {field_count_r[CNT_W-1:1], ~field_count_r[0]};
        end
        MODE_RELAY: begin
          if ((char_count_r < WSS_LEN) && (item.char_code != wss_char(char_count_r[2:0])))
            wss_m = 1'b0;
          if ((char_count_r < WS_LEN) && (item.char_code != ws_char(char_count_r[2:0])))
            ws_m = 1'b0;
        end
        MODE_KIND, MODE_TIME: begin
          if (!cls.is_dec) ok = 1'b0;
        end
        MODE_JSON: begin
          if (!seen_nonspace_r && !cls.is_white) begin
            seen = 1'b1;
            if (!cls.is_open) ok = 1'b0;
          end
          if (inside_quotes_r) begin
            priority if (escape_pending_r) esc = 1'b0;
            else if (cls.is_bslash)        esc = 1'b1;
            else if (cls.is_quote)         inq = 1'b0;
            else begin
              // other bytes inside quotes change nothing
            end
          end else begin
            priority if (cls.is_quote) begin
              inq = 1'b1;
            end else if (cls.is_open) begin
              if (nest_depth_r == {DEPTH_BITS{1'b1}}) ok = 1'b0;
              else dep = nest_depth_r + 1'b1;
            end else if (cls.is_close) begin
              if (nest_depth_r == '0) ok = 1'b0;
              else dep = nest_depth_r - 1'b1;
            end else begin
              // other bytes leave the depth alone
            end
          end
        end
        MODE_ADDR: begin
          if (addr_phase_r == PH_KIND) begin
            if (cls.is_colon) begin
              if (char_count_r == '0) ok = 1'b0;
              ph = PH_KEY;
            end else if (!cls.is_dec) begin
              ok = 1'b0;
            end
          end else if (addr_phase_r == PH_KEY) begin
            if (cls.is_colon) begin
              if (field_count_r != KEY_LEN_C) ok = 1'b0;
              ph = PH_TAG;
            end else begin
              if (!cls.is_hex) ok = 1'b0;
              if (field_count_r != CNT_MAX) fc = field_count_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (char_count_r != CNT_MAX) cc = char_count_r + 1'b1;
    end

    unique case (typ)
      MODE_ID, MODE_PUB:    verdict = ok && KEY_EVEN && (cc == KEY_LEN_C);
      MODE_RELAY:           verdict = (wss_m && (cc > WSS_LEN)) || (ws_m && (cc > WS_LEN));
      MODE_KIND, MODE_TIME: verdict = ok && (cc != '0);
      MODE_HEX:             verdict = ok && (cc != '0) && (fc == '0);
      MODE_JSON:            verdict = ok && seen && (dep == '0) && !inq;
      MODE_ADDR:            verdict = ok && ph[1];
      MODE_FREE:            verdict = 1'b1;
      default:              verdict = 1'b0;
    endcase

    latched_type_nxt = typ;
    if (item.last) begin
      in_progress_nxt    = 1'b0;
      still_ok_nxt       = 1'b1;
      char_count_nxt     = '0;
      field_count_nxt    = '0;
      addr_phase_nxt     = PH_KIND;
      wss_match_nxt      = 1'b1;
      ws_match_nxt       = 1'b1;
      seen_nonspace_nxt  = 1'b0;
      inside_quotes_nxt  = 1'b0;
      escape_pending_nxt = 1'b0;
      nest_depth_nxt     = '0;
    end else begin
      in_progress_nxt    = 1'b1;
      still_ok_nxt       = ok;
      char_count_nxt     = cc;
      field_count_nxt    = fc;
      addr_phase_nxt     = ph;
      wss_match_nxt      = wss_m;
      ws_match_nxt       = ws_m;
      seen_nonspace_nxt  = seen;
      inside_quotes_nxt  = inq;
      escape_pending_nxt = esc;
      nest_depth_nxt     = dep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_type_r   <= MODE_ID;
      in_progress_r    <= 1'b0;
      still_ok_r       <= 1'b1;
      char_count_r     <= '0;
      field_count_r    <= '0;
      addr_phase_r     <= PH_KIND;
      wss_match_r      <= 1'b1;
      ws_match_r       <= 1'b1;
      seen_nonspace_r  <= 1'b0;
      inside_quotes_r  <= 1'b0;
      escape_pending_r <= 1'b0;
      nest_depth_r     <= '0;
    end else if (step) begin
      latched_type_r   <= latched_type_nxt;
      in_progress_r    <= in_progress_nxt;
      still_ok_r       <= still_ok_nxt;
      char_count_r     <= char_count_nxt;
      field_count_r    <= field_count_nxt;
      addr_phase_r     <= addr_phase_nxt;
      wss_match_r      <= wss_match_nxt;
      ws_match_r       <= ws_match_nxt;
      seen_nonspace_r  <= seen_nonspace_nxt;
      inside_quotes_r  <= inside_quotes_nxt;
      escape_pending_r <= escape_pending_nxt;
      nest_depth_r     <= nest_depth_nxt;
    end
  end

endmodule

// ===== rtl/core/string_type_validator_unit.sv =====
// top level of the string type validator: input register, check core, verdict register
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_mode, in_char_code, in_char_present, in_last
//  out_    | output    | out_valid/out_stall| out_valid_res
//
// one item per cycle sustained unless a last item waits on a stalled output; a verdict is
// offered after its last item passes the input register and then the verdict register
// the per-string flags and counters are updated from the input register whenever an item leaves it
// reset is synchronous on rst_n low and clears the input and verdict stages and all string state
// a stall on the output only holds back last items; bytes inside a string keep flowing
// in_stall is high only while the input register holds a last item that cannot leave
module string_type_validator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [stv_pkg::MODE_W-1:0]    in_mode,
  input  logic [stv_pkg::CHAR_W-1:0]    in_char_code,
  input  logic                          in_char_present,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_valid_res
);
  import stv_pkg::*;

  // input register stage
  logic        s1_valid_r, s1_valid_nxt;
  item_t       s1_item_r;
  // verdict register stage
  logic        out_valid_r, out_valid_nxt;
  logic        out_res_r;

  logic        in_fire;
  logic        s1_go;
  logic        verdict;
  char_class_t cls;

  // a non-last item never waits for the output side
  assign s1_go    = s1_valid_r && (!s1_item_r.last || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire)    s1_valid_nxt = 1'b1;
    else if (s1_go) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (s1_go && s1_item_r.last)     out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.mode         <= in_mode;
      s1_item_r.char_code    <= in_char_code;
      s1_item_r.char_present <= in_char_present;
      s1_item_r.last         <= in_last;
    end
    if (s1_go && s1_item_r.last) begin
      out_res_r <= verdict;
    end
  end

  stv_char_class u_class (
    .char_code (s1_item_r.char_code),
    .cls       (cls)
  );

  stv_check_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_go),
    .item    (s1_item_r),
    .cls     (cls),
    .verdict (verdict)
  );

  assign out_valid     = out_valid_r;
  assign out_valid_res = out_res_r;

`ifndef SYNTHESIS
  // a fresh verdict only follows a last item leaving the input register
  a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_go && s1_item_r.last))
    else $error("verdict without a last item");

  // an empty input register never stalls the input side
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("stall with empty input register");

  // a held item stays put until it can move on
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("held item lost or changed");
`endif

endmodule
